// ----- design/cda_pkg.sv -----
// calendar date adder package: payload types, codes, constants and month table
package cda_pkg;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] amount;
    } req_t;

    typedef struct packed {
        logic [12:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
    } rsp_t;

    typedef struct packed {
        logic [12:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_LOAD = 3'd1,
        OP_YEAR = 3'd2,
        OP_PREP = 3'd3,
        OP_DIV  = 3'd4,
        OP_MFIN = 3'd5,
        OP_DAY  = 3'd6
    } op_t;

    typedef struct packed {
        rsp_t        date;
        logic [16:0] rem;
        logic [3:0]  modr;
        logic        last;
    } res_t;

    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_DAYS    = 2'd1;
    localparam logic [1:0] KIND_MONTHS  = 2'd2;
    localparam logic [1:0] KIND_YEARS   = 2'd3;

    localparam logic [1:0] CFG_START_YEAR  = 2'd0;
    localparam logic [1:0] CFG_START_MONTH = 2'd1;
    localparam logic [1:0] CFG_START_DAY   = 2'd2;

    localparam int RESET_YEAR  = 2021;
    localparam int RESET_MONTH = 11;
    localparam int RESET_DAY   = 19;

    // month index offset so the dividend is never negative: 12 * QUOT_BIAS
    localparam int DIV_BIAS  = 32772;
    localparam int QUOT_BIAS = 2731;

    // ceiling of 2^17 / 3
    localparam logic [15:0] RECIP_3 = 16'd43691;

    function automatic logic [4:0] month_len(logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- design/cda_unit.sv -----
// calendar date adder shared step unit: saturating year adder, day stepper, divide-by-12 step
module cda_unit #(
    parameter int unsigned MAX_YEAR = 5000
) (
    input  cda_pkg::op_t        op,
    input  cda_pkg::rsp_t       date,
    input  logic [16:0]         rem,
    input  logic [3:0]          modr,
    input  logic signed [15:0]  amount,
    input  cda_pkg::cfg_t       cfg,
    output cda_pkg::res_t       res
);

    localparam logic signed [18:0] MAX_SUM = 19'(MAX_YEAR);
    localparam logic [12:0]        MAX_Y13 = 13'(MAX_YEAR);

    logic signed [17:0] day_sum;
    logic [4:0]         len;
    logic [4:0]         prev_len;
    logic [3:0]         prev_month;
    logic [3:0]         next_month;
    logic               below;
    logic               above;
    logic signed [17:0] inc;
    logic signed [18:0] year_sum;
    logic [12:0]        year_sat;
    logic [14:0]        div_y;
    logic [30:0]        div_prod;
    logic [13:0]        div_q;
    logic [14:0]        div_r3;
    logic [3:0]         load_month;
    logic [4:0]         load_len;
    logic [4:0]         load_day;
    logic signed [17:0] prep_sum;

    assign day_sum    = 18'($signed(rem)) + $signed({13'b0, date.cur_day});
    assign len        = cda_pkg::month_len(date.cur_month);
    assign prev_month = (date.cur_month == 4'd1) ? 4'd12 : date.cur_month - 4'd1;
    assign next_month = (date.cur_month == 4'd12) ? 4'd1 : date.cur_month + 4'd1;
    assign prev_len   = cda_pkg::month_len(prev_month);
    assign below      = day_sum < 18'sd1;
    assign above      = day_sum > $signed({13'b0, len});
    assign prep_sum   = $signed({14'b0, date.cur_month}) + 18'(amount)
                        + 18'(cda_pkg::DIV_BIAS) - 18'sd1;

    // divide by 12 as a shift by 2 then a reciprocal multiply by 1/3
    assign div_y    = rem[16:2];
    assign div_prod = 31'(div_y) * 31'(cda_pkg::RECIP_3);
    assign div_q    = div_prod[30:17];
    assign div_r3   = div_y - ({div_q, 1'b0} + {1'b0, div_q});

    // restart values clipped to range
    always_comb
    begin
        if (cfg.start_month == 4'd0)
        begin
            load_month = 4'd1;
        end
        else if (cfg.start_month > 4'd12)
        begin
            load_month = 4'd12;
        end
        else
        begin
            load_month = cfg.start_month;
        end
        load_len = cda_pkg::month_len(load_month);
        if (cfg.start_day == 5'd0)
        begin
            load_day = 5'd1;
        end
        else if (cfg.start_day > load_len)
        begin
            load_day = load_len;
        end
        else
        begin
            load_day = cfg.start_day;
        end
    end

    // shared year adder
    always_comb
    begin
        unique case (op)
            cda_pkg::OP_YEAR: inc = 18'(amount);
            cda_pkg::OP_MFIN: inc = $signed({1'b0, rem}) - 18'(cda_pkg::QUOT_BIAS);
            cda_pkg::OP_DAY:
            begin
                if (below && date.cur_month == 4'd1)
                begin
                    inc = -18'sd1;
                end
                else if (!below && above && date.cur_month == 4'd12)
                begin
                    inc = 18'sd1;
                end
                else
                begin
                    inc = 18'sd0;
                end
            end
            default:          inc = 18'sd0;
        endcase
        year_sum = $signed({6'b0, date.cur_year}) + 19'(inc);
        if (year_sum < 19'sd0)
        begin
            year_sat = 13'd0;
        end
        else if (year_sum > MAX_SUM)
        begin
            year_sat = MAX_Y13;
        end
        else
        begin
            year_sat = year_sum[12:0];
        end
    end

    always_comb
    begin
        res.date = date;
        res.rem  = rem;
        res.modr = modr;
        res.last = 1'b0;
        unique case (op)
            cda_pkg::OP_LOAD:
            begin
                res.date.cur_year  = (cfg.start_year > MAX_Y13) ? MAX_Y13 : cfg.start_year;
                res.date.cur_month = load_month;
                res.date.cur_day   = load_day;
                res.last           = 1'b1;
            end
            cda_pkg::OP_YEAR:
            begin
                res.date.cur_year = year_sat;
                res.last          = 1'b1;
            end
            cda_pkg::OP_PREP:
            begin
                res.rem  = prep_sum[16:0];
                res.modr = 4'd0;
            end
            cda_pkg::OP_DIV:
            begin
                res.rem  = {3'b0, div_q};
                res.modr = {div_r3[1:0], rem[1:0]};
            end
            cda_pkg::OP_MFIN:
            begin
                res.date.cur_month = modr + 4'd1;
                res.date.cur_year  = year_sat;
                res.last           = 1'b1;
            end
            cda_pkg::OP_DAY:
            begin
                res.date.cur_year = year_sat;
                if (below)
                begin
                    res.rem            = day_sum[16:0];
                    res.date.cur_day   = prev_len;
                    res.date.cur_month = prev_month;
                end
                else if (above)
                begin
                    res.rem            = 17'(day_sum - $signed({13'b0, len}) - 18'sd1);
                    res.date.cur_day   = 5'd1;
                    res.date.cur_month = next_month;
                end
                else
                begin
                    res.date.cur_day = day_sum[4:0];
                    res.last         = 1'b1;
                end
            end
            default:
            begin
                res.last = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/calendar_date_adder.sv -----
// calendar date adder top level: sequencer, date state, config registers, result register
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    cda_pkg::req_t (kind, amount)
//  rsp      out        rsp_valid/rsp_ready    cda_pkg::rsp_t (cur_year, cur_month, cur_day)
//  cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  restart and year add: one step state (S_LOAD or S_YEAR), then S_DONE loads the result register
//  month add: the bias (S_PREP), divide-by-12 (S_DIV) and carry (S_MFIN) steps, then S_DONE
//  day add: S_DAY crosses one month boundary per cycle until the day fits, then S_DONE
//  one item at a time; req_ready is high only when idle, also while a result waits
//  asynchronous active-low reset loads the date 2021-11-19 (year capped at MAX_YEAR) and the same start registers
module calendar_date_adder #(
    parameter int unsigned MAX_YEAR = 5000
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cda_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output cda_pkg::rsp_t  rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [12:0]    cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_YEAR = 8'b0000_0100,
        S_DAY  = 8'b0000_1000,
        S_PREP = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_MFIN = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    localparam logic [12:0] RST_YEAR =
        13'((MAX_YEAR < cda_pkg::RESET_YEAR) ? MAX_YEAR : cda_pkg::RESET_YEAR);

    state_t              state_reg, state_next;
    cda_pkg::rsp_t       date_reg, date_next;
    logic [16:0]         rem_reg, rem_next;
    logic [3:0]          mod_reg, mod_next;
    logic signed [15:0]  amount_reg, amount_next;
    cda_pkg::cfg_t       cfg_reg, cfg_next;
    cda_pkg::rsp_t       rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;
    cda_pkg::op_t        op;
    cda_pkg::res_t       res;
    logic                req_take;
    logic                rsp_free;

    assign req_ready = (state_reg == S_IDLE);
    assign req_take  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    cda_unit #(
        .MAX_YEAR (MAX_YEAR)
    ) u_cda_unit (
        .op     (op),
        .date   (date_reg),
        .rem    (rem_reg),
        .modr   (mod_reg),
        .amount (amount_reg),
        .cfg    (cfg_reg),
        .res    (res)
    );

    always_comb
    begin
        unique case (state_reg)
            S_LOAD:  op = cda_pkg::OP_LOAD;
            S_YEAR:  op = cda_pkg::OP_YEAR;
            S_DAY:   op = cda_pkg::OP_DAY;
            S_PREP:  op = cda_pkg::OP_PREP;
            S_DIV:   op = cda_pkg::OP_DIV;
            S_MFIN:  op = cda_pkg::OP_MFIN;
            default: op = cda_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        date_next   = res.date;
        rem_next    = res.rem;
        mod_next    = res.modr;
        amount_next = amount_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    amount_next = req.amount;
                    rem_next    = 17'(req.amount);
                    unique case (req.kind)
                        cda_pkg::KIND_RESTART: state_next = S_LOAD;
                        cda_pkg::KIND_DAYS:    state_next = S_DAY;
                        cda_pkg::KIND_MONTHS:  state_next = S_PREP;
                        cda_pkg::KIND_YEARS:   state_next = S_YEAR;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD, S_YEAR, S_MFIN:
            begin
                state_next = S_DONE;
            end
            S_DAY:
            begin
                if (res.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_PREP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_MFIN;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        priority if (state_reg == S_DONE && rsp_free)
        begin
            rsp_next       = date_reg;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                cda_pkg::CFG_START_YEAR:  cfg_next.start_year  = cfg_data;
                cda_pkg::CFG_START_MONTH: cfg_next.start_month = cfg_data[3:0];
                cda_pkg::CFG_START_DAY:   cfg_next.start_day   = cfg_data[4:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            date_reg.cur_year     <= RST_YEAR;
            date_reg.cur_month    <= 4'(cda_pkg::RESET_MONTH);
            date_reg.cur_day      <= 5'(cda_pkg::RESET_DAY);
            cfg_reg.start_year    <= 13'(cda_pkg::RESET_YEAR);
            cfg_reg.start_month   <= 4'(cda_pkg::RESET_MONTH);
            cfg_reg.start_day     <= 5'(cda_pkg::RESET_DAY);
            rsp_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            date_reg      <= date_next;
            cfg_reg       <= cfg_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        mod_reg    <= mod_next;
        amount_reg <= amount_next;
        rsp_reg    <= rsp_next;
    end

endmodule

// ----- design/cda_checker.sv -----
// calendar date adder port checker and its bind to the top level
module cda_checker #(
    parameter int unsigned MAX_YEAR = 5000
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input cda_pkg::rsp_t rsp
);

    // a waiting result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed or dropped while stalled");

    // one item at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready again right after an item was taken");

    a_month_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.cur_month >= 4'd1 && rsp.cur_month <= 4'd12 && rsp.cur_day >= 5'd1)
        else $error("month or day out of range");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.cur_year <= 13'(MAX_YEAR))
        else $error("year above its bound");

endmodule

bind calendar_date_adder cda_checker #(.MAX_YEAR(MAX_YEAR)) u_cda_checker (.*);

// ----- tb/tb_calendar_date_adder.sv -----
// self-checking testbench for calendar_date_adder: directed and random date steps
`timescale 1ns / 1ps

module tb_calendar_date_adder;

    localparam int YEAR_CAP  = 5000;
    localparam int LONG_HOLD = 300;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    cda_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    cda_pkg::rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [12:0] cfg_data;

    // shadow of the date and the start registers
    int yr;
    int mo;
    int dy;
    logic [12:0] st_year;
    logic [3:0] st_month;
    logic [4:0] st_day;

    cda_pkg::rsp_t due_dates[$];
    int err_count;
    bit steady;
    bit hold_req;
    bit hold_ack;

    calendar_date_adder #(
        .MAX_YEAR(YEAR_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    function automatic int days_in(int m);
        case (clamp(m, 1, 12))
            2:            return 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic void shift_years(int inc);
        yr = clamp(yr + inc, 0, YEAR_CAP);
    endfunction

    function automatic void shift_months(int inc);
        int idx;
        int carry;
        idx = mo - 1 + inc;
        if (idx >= 0)
            carry = idx / 12;
        else
            carry = -((11 - idx) / 12);
        mo = idx - carry * 12 + 1;
        shift_years(carry);
    endfunction

    // walks one month boundary per pass, as the block does
    function automatic void shift_days(int inc);
        int left;
        int sum;
        left = inc;
        while (1'b1)
        begin
            sum = dy + left;
            if (sum < 1)
            begin
                left = left + dy;
                dy = days_in(mo == 1 ? 12 : mo - 1);
                shift_months(-1);
            end
            else if (sum > days_in(mo))
            begin
                left = sum - days_in(mo) - 1;
                dy = 1;
                shift_months(1);
            end
            else
            begin
                dy = sum;
                break;
            end
        end
    endfunction

    function automatic cda_pkg::rsp_t advance_date(cda_pkg::req_t item);
        cda_pkg::rsp_t d;
        case (item.kind)
            cda_pkg::KIND_RESTART:
            begin
                yr = clamp(int'(st_year), 0, YEAR_CAP);
                mo = clamp(int'(st_month), 1, 12);
                dy = clamp(int'(st_day), 1, days_in(mo));
            end
            cda_pkg::KIND_DAYS:   shift_days(int'(item.amount));
            cda_pkg::KIND_MONTHS: shift_months(int'(item.amount));
            default:              shift_years(int'(item.amount));
        endcase
        d.cur_year  = yr[12:0];
        d.cur_month = mo[3:0];
        d.cur_day   = dy[4:0];
        return d;
    endfunction

    // span 0 gives the full signed range
    function automatic logic signed [15:0] rand_amount(int span);
        if (span == 0)
            return 16'($urandom_range(0, 65535));
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic offer_item(logic [1:0] kind, logic signed [15:0] amount);
        cda_pkg::req_t item;
        item.kind = kind;
        item.amount = amount;
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        due_dates.push_back(advance_date(item));
        if (!steady && $urandom_range(99) < 29)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 29);
        end
    endtask

    task automatic drain;
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_dates.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            cda_pkg::CFG_START_YEAR:  st_year = val;
            cda_pkg::CFG_START_MONTH: st_month = val[3:0];
            cda_pkg::CFG_START_DAY:   st_day = val[4:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_start(logic [12:0] y, logic [12:0] m, logic [12:0] d);
        write_reg(cda_pkg::CFG_START_YEAR, y);
        write_reg(cda_pkg::CFG_START_MONTH, m);
        write_reg(cda_pkg::CFG_START_DAY, d);
    endtask

    task automatic offer_random_item;
        int r;
        int p;
        r = $urandom_range(99);
        p = $urandom_range(99);
        if (r < 6)
            offer_item(cda_pkg::KIND_RESTART, rand_amount(0));
        else if (r < 50)
            offer_item(cda_pkg::KIND_DAYS, rand_amount(p < 80 ? 60 : (p < 97 ? 800 : 0)));
        else if (r < 75)
            offer_item(cda_pkg::KIND_MONTHS, rand_amount(p < 70 ? 30 : 0));
        else
            offer_item(cda_pkg::KIND_YEARS, rand_amount(p < 70 ? 50 : 0));
    endtask

    task automatic test_reset_date;
        offer_item(cda_pkg::KIND_YEARS, 16'sd0);
        offer_item(cda_pkg::KIND_RESTART, 16'sh7FFF);
        drain();
    endtask

    task automatic test_extreme_amounts;
        offer_item(cda_pkg::KIND_DAYS, 16'sh7FFF);
        offer_item(cda_pkg::KIND_DAYS, 16'sh8000);
        offer_item(cda_pkg::KIND_MONTHS, 16'sh7FFF);
        offer_item(cda_pkg::KIND_MONTHS, 16'sh8000);
        drain();
    endtask

    task automatic test_year_bounds;
        offer_item(cda_pkg::KIND_YEARS, 16'sh7FFF);
        offer_item(cda_pkg::KIND_MONTHS, 16'sd25);
        offer_item(cda_pkg::KIND_DAYS, 16'sd400);
        offer_item(cda_pkg::KIND_YEARS, 16'sh8000);
        offer_item(cda_pkg::KIND_MONTHS, -16'sd30);
        offer_item(cda_pkg::KIND_DAYS, -16'sd500);
        drain();
    endtask

    task automatic test_month_keeps_day;
        set_start(13'd2000, 13'd1, 13'd31);
        offer_item(cda_pkg::KIND_RESTART, 16'sd0);
        offer_item(cda_pkg::KIND_MONTHS, 16'sd1);
        offer_item(cda_pkg::KIND_DAYS, 16'sd0);
        drain();
    endtask

    task automatic test_back_from_january;
        write_reg(cda_pkg::CFG_START_DAY, 13'd1);
        offer_item(cda_pkg::KIND_RESTART, 16'sd0);
        offer_item(cda_pkg::KIND_DAYS, -16'sd1);
        offer_item(cda_pkg::KIND_RESTART, 16'sd0);
        offer_item(cda_pkg::KIND_MONTHS, -16'sd1);
        drain();
    endtask

    task automatic test_restart_clipping;
        set_start(13'd8191, 13'd0, 13'd0);
        offer_item(cda_pkg::KIND_RESTART, 16'sd0);
        drain();
        set_start(13'd0, 13'd15, 13'd31);
        offer_item(cda_pkg::KIND_RESTART, 16'sd0);
        drain();
        set_start(13'd5000, 13'd2, 13'd31);
        offer_item(cda_pkg::KIND_RESTART, 16'sd0);
        drain();
        // upper data bits set on the narrow registers
        set_start(13'd3000, 13'h1FFD, 13'h1FE0);
        offer_item(cda_pkg::KIND_RESTART, 16'sd0);
        drain();
    endtask

    task automatic test_random_walk;
        int ph;
        int n;
        for (ph = 0; ph < 6; ph++)
        begin
            steady = (ph == 3);
            set_start($urandom_range(99) < 85 ? 13'($urandom_range(0, YEAR_CAP))
                                               : 13'($urandom_range(0, 8191)),
                      13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
            offer_item(cda_pkg::KIND_RESTART, rand_amount(0));
            for (n = 0; n < 99; n++)
                offer_random_item();
            drain();
        end
        steady = 1'b0;
    endtask

    task automatic test_output_stall;
        int n;
        hold_req = ~hold_req;
        for (n = 0; n < 10; n++)
            offer_random_item();
        drain();
    endtask

    initial
    begin : rsp_side
        int n;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                rsp_ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++)
                    @(posedge clk);
            end
            rsp_ready <= steady || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge clk)
    begin : date_check
        cda_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_dates.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result %0d-%0d-%0d", $time,
                         rsp.cur_year, rsp.cur_month, rsp.cur_day);
            end
            else
            begin
                want = due_dates.pop_front();
                if (rsp.cur_year != want.cur_year)
                begin
                    err_count++;
                    $display("%0t: cur_year expected %0d actual %0d", $time,
                             want.cur_year, rsp.cur_year);
                end
                if (rsp.cur_month != want.cur_month)
                begin
                    err_count++;
                    $display("%0t: cur_month expected %0d actual %0d", $time,
                             want.cur_month, rsp.cur_month);
                end
                if (rsp.cur_day != want.cur_day)
                begin
                    err_count++;
                    $display("%0t: cur_day expected %0d actual %0d", $time,
                             want.cur_day, rsp.cur_day);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = cda_pkg::CFG_START_YEAR;
        cfg_data = '0;
        err_count = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        st_year = 13'(cda_pkg::RESET_YEAR);
        st_month = 4'(cda_pkg::RESET_MONTH);
        st_day = 5'(cda_pkg::RESET_DAY);
        yr = clamp(cda_pkg::RESET_YEAR, 0, YEAR_CAP);
        mo = cda_pkg::RESET_MONTH;
        dy = cda_pkg::RESET_DAY;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_date();
        test_extreme_amounts();
        test_year_bounds();
        test_month_keeps_day();
        test_back_from_january();
        test_restart_clipping();
        test_random_walk();
        test_output_stall();

        repeat (40)
            @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- calendar_date_adder.f -----
design/cda_pkg.sv
design/cda_unit.sv
design/calendar_date_adder.sv
design/cda_checker.sv
tb/tb_calendar_date_adder.sv
